// ----- hw/rtl/bbp_pkg.sv -----
package bbp_pkg;

    // Grid geometry
    localparam int GRID_SIDE   = 4;
    localparam int GRID_POINTS = GRID_SIDE * GRID_SIDE;
    localparam int INDEX_W     = 4;

    // Number formats
    localparam int COORD_W = 32;
    localparam int PARAM_W = 17;
    localparam int FRAC_W  = 16;
    localparam logic [PARAM_W-1:0] ONE_Q16 = 17'h10000;

    // Pipeline depth of one lerp and of one bilinear round
    localparam int LERP_STAGES  = 3;
    localparam int ROUND_STAGES = 2 * LERP_STAGES;

    // Item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic                      mode;
        logic [INDEX_W-1:0]        point_index;
        logic signed [COORD_W-1:0] load_x;
        logic signed [COORD_W-1:0] load_y;
        logic signed [COORD_W-1:0] load_z;
        logic [PARAM_W-1:0]        param_u;
        logic [PARAM_W-1:0]        param_v;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } result_t;

    // Control that travels with each evaluation through the rounds
    typedef struct packed {
        logic               valid;
        logic [PARAM_W-1:0] u;
        logic [PARAM_W-1:0] v;
    } ctl_t;

endpackage

// ----- hw/rtl/bbp_lerp.sv -----
// Three-stage lerp on a 3D point: y = a + (((b - a) * t) >>> 16)
module bbp_lerp (
    input  logic                          clk,
    input  logic                          en,
    input  bbp_pkg::point_t               a,
    input  bbp_pkg::point_t               b,
    input  logic [bbp_pkg::PARAM_W-1:0]   t,
    output bbp_pkg::point_t               y
);

    localparam int DIFF_W = bbp_pkg::COORD_W + 1;
    localparam int PROD_W = DIFF_W + bbp_pkg::PARAM_W + 1;
    localparam int SEL_LO = bbp_pkg::FRAC_W;
    localparam int SEL_HI = bbp_pkg::FRAC_W + bbp_pkg::COORD_W - 1;

    bbp_pkg::point_t             a1_reg;
    bbp_pkg::point_t             a2_reg;
    bbp_pkg::point_t             y_reg;
    logic [bbp_pkg::PARAM_W-1:0] t1_reg;
    logic signed [DIFF_W-1:0]    dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_W-1:0]    dx_next, dy_next, dz_next;
    logic signed [PROD_W-1:0]    px_reg, py_reg, pz_reg;
    logic signed [PROD_W-1:0]    px_next, py_next, pz_next;
    logic signed [bbp_pkg::PARAM_W:0] t_signed;
    bbp_pkg::point_t             y_next;

    // Stage 1: difference, 33 bits so it cannot wrap
    always_comb
    begin
        dx_next = {b.x[bbp_pkg::COORD_W-1], b.x} - {a.x[bbp_pkg::COORD_W-1], a.x};
        dy_next = {b.y[bbp_pkg::COORD_W-1], b.y} - {a.y[bbp_pkg::COORD_W-1], a.y};
        dz_next = {b.z[bbp_pkg::COORD_W-1], b.z} - {a.z[bbp_pkg::COORD_W-1], a.z};
    end

    // Stage 2: signed product with the non-negative weight
    assign t_signed = $signed({1'b0, t1_reg});

    always_comb
    begin
        px_next = PROD_W'(dx_reg) * PROD_W'(t_signed);
        py_next = PROD_W'(dy_reg) * PROD_W'(t_signed);
        pz_next = PROD_W'(dz_reg) * PROD_W'(t_signed);
    end

    // Stage 3: floor shift is a bit select; result always fits in 32 bits
    always_comb
    begin
        y_next.x = a2_reg.x + px_reg[SEL_HI:SEL_LO];
        y_next.y = a2_reg.y + py_reg[SEL_HI:SEL_LO];
        y_next.z = a2_reg.z + pz_reg[SEL_HI:SEL_LO];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= a;
            t1_reg <= t;
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
            a2_reg <= a1_reg;
            px_reg <= px_next;
            py_reg <= py_next;
            pz_reg <= pz_next;
            y_reg  <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ----- hw/rtl/bbp_round.sv -----
// One bilinear de Casteljau round: (SIDE+1)^2 points in, SIDE^2 points out.
// Lerps along i by u first, then along j by v; six register stages.
module bbp_round #(
    parameter int SIDE = bbp_pkg::GRID_SIDE - 1
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  bbp_pkg::ctl_t                            ctl_in,
    input  bbp_pkg::point_t [(SIDE+1)*(SIDE+1)-1:0]  pts_in,
    output bbp_pkg::ctl_t                            ctl_out,
    output bbp_pkg::point_t [SIDE*SIDE-1:0]          pts_out
);

    localparam int IN_SIDE = SIDE + 1;
    localparam int MID_PTS = SIDE * IN_SIDE;

    bbp_pkg::ctl_t                 ctl_reg [bbp_pkg::ROUND_STAGES];
    bbp_pkg::point_t [MID_PTS-1:0] mid;

    // Control shift line, in step with the lerp stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < bbp_pkg::ROUND_STAGES; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int k = 1; k < bbp_pkg::ROUND_STAGES; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // Lerps along i: mid[i][j] = lerp(p[i][j], p[i+1][j], u), j over all columns
    for (genvar gi = 0; gi < SIDE; gi++)
    begin : g_u_row
        for (genvar gj = 0; gj < IN_SIDE; gj++)
        begin : g_u_col
            bbp_lerp u_lerp (
                .clk (clk),
                .en  (en),
                .a   (pts_in[gi*IN_SIDE + gj]),
                .b   (pts_in[(gi+1)*IN_SIDE + gj]),
                .t   (ctl_in.u),
                .y   (mid[gi*IN_SIDE + gj])
            );
        end
    end

    // Lerps along j: out[i][j] = lerp(mid[i][j], mid[i][j+1], v)
    for (genvar gi = 0; gi < SIDE; gi++)
    begin : g_v_row
        for (genvar gj = 0; gj < SIDE; gj++)
        begin : g_v_col
            bbp_lerp v_lerp (
                .clk (clk),
                .en  (en),
                .a   (mid[gi*IN_SIDE + gj]),
                .b   (mid[gi*IN_SIDE + gj + 1]),
                .t   (ctl_reg[bbp_pkg::LERP_STAGES-1].v),
                .y   (pts_out[gi*SIDE + gj])
            );
        end
    end

    assign ctl_out = ctl_reg[bbp_pkg::ROUND_STAGES-1];

    // A held pipeline keeps its last stage
    a_hold_ctl: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(ctl_out))
        else $error("round control moved while the pipeline was held");

endmodule

// ----- hw/rtl/bicubic_bezier_patch_eval.sv -----
// Bicubic Bezier patch evaluator, tensor-product de Casteljau.
//
// Input channel (item_valid / item_stall / item): mode MODE_LOAD writes one
// control point at point_index and gives no result; mode MODE_EVAL gives one
// surface point at (param_u, param_v), each clamped to one (65536).
// Output channel (point_valid / point_stall / point): one transaction per
// evaluation, in acceptance order.
// Throughput: one item per cycle while item_stall is low; the pipeline is three
// rounds of six stages each (subtract, multiply, add for u, then for v).
// An evaluation samples the grid when it is accepted, so a load taken in the
// next cycle already counts for the evaluation after it.
// Reset clears the grid to all zero and empties the pipeline.
// When the receiver stalls, one result waits in the output register and one
// more in a skid register; with the skid register full item_stall goes high
// and the whole pipeline holds until the receiver takes a result.
module bicubic_bezier_patch_eval (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  bbp_pkg::item_t    item,
    output logic              point_valid,
    input  logic              point_stall,
    output bbp_pkg::result_t  point
);

    localparam int R1_SIDE = bbp_pkg::GRID_SIDE - 1;
    localparam int R2_SIDE = bbp_pkg::GRID_SIDE - 2;
    localparam int R3_SIDE = bbp_pkg::GRID_SIDE - 3;

    bbp_pkg::point_t [bbp_pkg::GRID_POINTS-1:0] grid_reg;
    bbp_pkg::point_t [bbp_pkg::GRID_POINTS-1:0] pts0_reg;
    bbp_pkg::ctl_t                              ctl0_reg;
    bbp_pkg::ctl_t                              ctl0_next;

    bbp_pkg::ctl_t                          ctl1, ctl2, ctl3;
    bbp_pkg::point_t [R1_SIDE*R1_SIDE-1:0]  pts1;
    bbp_pkg::point_t [R2_SIDE*R2_SIDE-1:0]  pts2;
    bbp_pkg::point_t [R3_SIDE*R3_SIDE-1:0]  pts3;

    logic             en;
    logic             accept;
    logic             push;
    logic             take;
    logic             out_load;
    logic             skid_load;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    bbp_pkg::point_t  out_data_reg, out_data_next;
    bbp_pkg::point_t  skid_data_reg;
    bbp_pkg::point_t  load_pt;

    // Pipeline moves whenever the skid register is free
    assign en         = !skid_valid_reg;
    assign item_stall = skid_valid_reg;
    assign accept     = item_valid && en;

    assign load_pt.x = item.load_x;
    assign load_pt.y = item.load_y;
    assign load_pt.z = item.load_z;

    // Entry stage: clamp parameters above one
    always_comb
    begin
        ctl0_next.valid = accept && (item.mode == bbp_pkg::MODE_EVAL);
        ctl0_next.u     = (item.param_u > bbp_pkg::ONE_Q16) ? bbp_pkg::ONE_Q16 : item.param_u;
        ctl0_next.v     = (item.param_v > bbp_pkg::ONE_Q16) ? bbp_pkg::ONE_Q16 : item.param_v;
    end

    // Control grid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= '0;
        end
        else if (accept && (item.mode == bbp_pkg::MODE_LOAD))
        begin
            grid_reg[item.point_index] <= load_pt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl0_reg <= '0;
        end
        else if (en)
        begin
            ctl0_reg <= ctl0_next;
        end
    end

    // Grid snapshot for the evaluation entering the rounds
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pts0_reg <= grid_reg;
        end
    end

    // Three reduction rounds: 4x4 -> 3x3 -> 2x2 -> 1x1
    bbp_round #(.SIDE(R1_SIDE)) u_round1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl0_reg),
        .pts_in  (pts0_reg),
        .ctl_out (ctl1),
        .pts_out (pts1)
    );

    bbp_round #(.SIDE(R2_SIDE)) u_round2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl1),
        .pts_in  (pts1),
        .ctl_out (ctl2),
        .pts_out (pts2)
    );

    bbp_round #(.SIDE(R3_SIDE)) u_round3 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (ctl2),
        .pts_in  (pts2),
        .ctl_out (ctl3),
        .pts_out (pts3)
    );

    // Output register with skid behind it
    assign push = en && ctl3.valid;
    assign take = !out_valid_reg || !point_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        skid_load       = 1'b0;
        out_data_next   = skid_valid_reg ? skid_data_reg : pts3[0];
        if (take)
        begin
            out_valid_next  = skid_valid_reg || push;
            skid_valid_next = 1'b0;
            out_load        = 1'b1;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
        if (skid_load)
        begin
            skid_data_reg <= pts3[0];
        end
    end

    assign point_valid   = out_valid_reg;
    assign point.point_x = out_data_reg.x;
    assign point.point_y = out_data_reg.y;
    assign point.point_z = out_data_reg.z;

    // Skid register only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result with the output register empty");

    // A result arriving at a stalled output is caught by the skid register
    a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && point_stall) |=> (skid_valid_reg && out_valid_reg))
        else $error("result lost at a stalled output");

    // A taken output drains the skid register
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !point_stall) |=> !skid_valid_reg)
        else $error("skid register did not drain");

    // An accepted evaluation enters the rounds
    a_eval_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && (item.mode == bbp_pkg::MODE_EVAL)) |=> ctl0_reg.valid)
        else $error("accepted evaluation did not enter the pipeline");

endmodule

// ----- bench/bbp_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, keeps its own copy of the control grid, predicts
// every evaluation and compares each returned point with the oldest one due.
module bbp_checker
    import bbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    point_valid,
    input  logic    point_stall,
    input  result_t point,
    output int      mismatches,
    output int      outstanding
);

    localparam int AXIS_X      = 0;
    localparam int AXIS_Y      = 1;
    localparam int AXIS_Z      = 2;
    localparam int MAX_REPORTS = 10;

    point_t  control_pts [GRID_POINTS];
    result_t expected_points [$];
    int      fail_count    = 0;
    int      pending_count = 0;

    assign mismatches  = fail_count;
    assign outstanding = pending_count;

    // a + floor((b - a) * t / 2^16); all terms fit easily in 64 bits
    function automatic longint lerp_q16(input longint a, input longint b, input longint t);
        longint prod;
        prod = (b - a) * t;
        return a + (prod >>> FRAC_W);
    endfunction

    // One coordinate of the surface point: three bilinear reduction rounds
    function automatic logic signed [COORD_W-1:0] surface_coord(input int axis,
                                                                input longint u,
                                                                input longint v);
        longint g [GRID_SIDE][GRID_SIDE];
        longint lo;
        longint hi;
        longint res;
        for (int i = 0; i < GRID_SIDE; i++)
        begin
            for (int j = 0; j < GRID_SIDE; j++)
            begin
                case (axis)
                    AXIS_X:  g[i][j] = longint'(control_pts[i*GRID_SIDE + j].x);
                    AXIS_Y:  g[i][j] = longint'(control_pts[i*GRID_SIDE + j].y);
                    default: g[i][j] = longint'(control_pts[i*GRID_SIDE + j].z);
                endcase
            end
        end
        for (int r = 1; r < GRID_SIDE; r++)
        begin
            for (int i = 0; i < GRID_SIDE - r; i++)
            begin
                for (int j = 0; j < GRID_SIDE - r; j++)
                begin
                    lo      = lerp_q16(g[i][j],     g[i+1][j],     u);
                    hi      = lerp_q16(g[i][j+1],   g[i+1][j+1],   u);
                    g[i][j] = lerp_q16(lo, hi, v);
                end
            end
        end
        res = g[0][0];
        return res[COORD_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s: expected (%h %h %h) got (%h %h %h)", $realtime, what,
                     want.point_x, want.point_y, want.point_z,
                     got.point_x, got.point_y, got.point_z);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        result_t want;
        longint  u;
        longint  v;
        if (!rst_n)
        begin
            for (int k = 0; k < GRID_POINTS; k++)
                control_pts[k] = '0;
            expected_points.delete();
            pending_count <= 0;
        end
        else
        begin
            // returned point against the oldest prediction
            if (point_valid && !point_stall)
            begin
                if (expected_points.size() == 0)
                    report_mismatch("result with none expected", '0, point);
                else
                begin
                    want = expected_points.pop_front();
                    if (point.point_x !== want.point_x)
                        report_mismatch("point_x mismatch", want, point);
                    if (point.point_y !== want.point_y)
                        report_mismatch("point_y mismatch", want, point);
                    if (point.point_z !== want.point_z)
                        report_mismatch("point_z mismatch", want, point);
                end
            end

            // accepted transaction: load updates the grid, evaluate predicts
            if (item_valid && !item_stall)
            begin
                if (item.mode == MODE_LOAD)
                begin
                    control_pts[item.point_index].x = item.load_x;
                    control_pts[item.point_index].y = item.load_y;
                    control_pts[item.point_index].z = item.load_z;
                end
                else
                begin
                    u = longint'((item.param_u > ONE_Q16) ? ONE_Q16 : item.param_u);
                    v = longint'((item.param_v > ONE_Q16) ? ONE_Q16 : item.param_v);
                    want.point_x = surface_coord(AXIS_X, u, v);
                    want.point_y = surface_coord(AXIS_Y, u, v);
                    want.point_z = surface_coord(AXIS_Z, u, v);
                    expected_points.push_back(want);
                end
            end
            pending_count <= expected_points.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import bbp_pkg::*;

    localparam int N_RANDOM     = 1450;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    item_valid  = 1'b0;
    item_t   item        = '0;
    logic    point_stall = 1'b0;
    logic    item_stall;
    logic    point_valid;
    result_t point;
    int      mismatches;
    int      outstanding;
    int      cycles      = 0;
    int      calm_items  = 0;

    always #6 clk = ~clk;

    bicubic_bezier_patch_eval uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point)
    );

    bbp_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("** bicubic_bezier_patch_eval: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure: mostly short stalls, a few long, some calm runs
    initial
    begin : backpressure
        int run;
        int hold;
        forever
        begin
            run = ($urandom_range(0, 99) < 5) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 6);
            repeat (run) @(posedge clk);
            point_stall <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                : $urandom_range(1, 3);
            repeat (hold) @(posedge clk);
            point_stall <= 1'b0;
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3:       return 32'($urandom_range(0, 131071)) - 32'd65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [PARAM_W-1:0] rand_param();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return PARAM_W'($urandom_range(65537, 131071));
            3:       return PARAM_W'($urandom_range(0, 131071));
            default: return PARAM_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // params are don't-care on a load, so they carry noise
    function automatic item_t load_item(input logic [INDEX_W-1:0] idx,
                                        input logic signed [COORD_W-1:0] x,
                                        input logic signed [COORD_W-1:0] y,
                                        input logic signed [COORD_W-1:0] z);
        item_t it;
        it.mode        = MODE_LOAD;
        it.point_index = idx;
        it.load_x      = x;
        it.load_y      = y;
        it.load_z      = z;
        it.param_u     = PARAM_W'($urandom);
        it.param_v     = PARAM_W'($urandom);
        return it;
    endfunction

    // index and coordinates are don't-care on an evaluate
    function automatic item_t eval_item(input logic [PARAM_W-1:0] u,
                                        input logic [PARAM_W-1:0] v);
        item_t it;
        it.mode        = MODE_EVAL;
        it.point_index = INDEX_W'($urandom);
        it.load_x      = $urandom;
        it.load_y      = $urandom;
        it.load_z      = $urandom;
        it.param_u     = u;
        it.param_v     = v;
        return it;
    endfunction

    // one transaction on the item channel, with a random idle gap ahead of it
    task automatic send(input item_t it);
        int gap;
        int r;
        if (calm_items > 0)
        begin
            calm_items--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                calm_items = $urandom_range(30, 150);
                gap = 0;
            end
            else if (r < 55)
                gap = 0;
            else if (r < 92)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int sent;
        int burst;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty grid after reset
        send(eval_item('0, '0));

        // grid of extreme coordinates, alternating signs
        for (int k = 0; k < GRID_POINTS; k++)
            send(load_item(INDEX_W'(k), k[0] ? COORD_MAX : COORD_MIN,
                                        k[1] ? COORD_MIN : COORD_MAX,
                                        k[2] ? COORD_MIN : COORD_MAX));

        // corners, center, near-one fractions and parameters above one
        send(eval_item('0, '0));
        send(eval_item(ONE_Q16, ONE_Q16));
        send(eval_item('0, ONE_Q16));
        send(eval_item(ONE_Q16, '0));
        send(eval_item(17'd32768, 17'd32768));
        send(eval_item(17'd1, 17'd65535));
        send(eval_item(17'h1ffff, 17'h10001));

        // random part: fresh grids followed by evaluation bursts, plus noise
        sent = 0;
        while (sent < N_RANDOM)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                for (int k = 0; k < GRID_POINTS; k++)
                    send(load_item(INDEX_W'(k), rand_coord(), rand_coord(), rand_coord()));
                burst = $urandom_range(4, 20);
                repeat (burst) send(eval_item(rand_param(), rand_param()));
                sent += GRID_POINTS + burst;
            end
            else
            begin
                if ($urandom_range(0, 99) < 35)
                    send(load_item(INDEX_W'($urandom_range(0, 15)), rand_coord(),
                                   rand_coord(), rand_coord()));
                else
                    send(eval_item(rand_param(), rand_param()));
                sent++;
            end
        end
        item_valid <= 1'b0;

        // drain the pipeline, then watch a little longer for strays
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("** bicubic_bezier_patch_eval: PASSED **");
        else
            $display("** bicubic_bezier_patch_eval: FAILED **");
        $finish;
    end

endmodule
